// ===== rtl/extent_map_block_translator_assert.svh =====
// assertion macros used by the extent map translator controller
`ifndef EXTENT_MAP_BLOCK_TRANSLATOR_ASSERT_SVH
`define EXTENT_MAP_BLOCK_TRANSLATOR_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define EMBT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next cycle
`define EMBT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/embt_pkg.sv =====
// ----------------------------------------------------------------------------
// embt_pkg
// shared constants, codes and controller/datapath types of the extent map
// block translator
// ----------------------------------------------------------------------------
`default_nettype none

package embt_pkg;

  // map storage geometry
  localparam int MAP_WORDS = 256;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  // word position, wide enough for a pointer that starts on the last word
  localparam int POS_W     = $clog2(MAP_WORDS + 4);

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_XLATE = 1'b1;

  // result codes
  typedef enum logic [1:0] {
    RESP_OK  = 2'd0,
    RESP_EOF = 2'd1,
    RESP_BAD = 2'd2,
    RESP_ACK = 2'd3
  } resp_code_t;

  // retrieval pointer types, bits 15:14 of the first word
  typedef enum logic [1:0] {
    PTR_NONE  = 2'd0,
    PTR_SHORT = 2'd1,
    PTR_MID   = 2'd2,
    PTR_LONG  = 2'd3
  } ptr_type_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_EVAL,
    ST_CMP,
    ST_LBN,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic wr;
    logic walk_init;
    logic rd_first;
    logic fetch;
    logic eval;
    logic advance;
    logic make_lbn;
    logic make_eof;
    logic make_ack;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic kind;
    logic more;
    logic fetch_last;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/embt_in_if.sv =====
// ----------------------------------------------------------------------------
// embt_in_if
// input channel: map word writes and block translation requests
// ----------------------------------------------------------------------------
`default_nettype none

interface embt_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  word_index;
  logic [15:0] map_word;
  logic [30:0] virtual_block;

  modport source (output valid, kind, word_index, map_word, virtual_block, input ready);
  modport sink   (input valid, kind, word_index, map_word, virtual_block, output ready);
endinterface

`default_nettype wire

// ===== rtl/embt_out_if.sv =====
// ----------------------------------------------------------------------------
// embt_out_if
// result channel: logical block number and status
// ----------------------------------------------------------------------------
`default_nettype none

interface embt_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] logical_block;
  logic [1:0]  status;

  modport source (output valid, logical_block, status, input ready);
  modport sink   (input valid, logical_block, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/extent_map_block_translator.sv =====
// ----------------------------------------------------------------------------
// extent_map_block_translator: map word store and vbn to lbn translation
// one item at a time; a map write gives its beat through the emit state and the output register
// a translation walks the map pointer by pointer, reading each pointer word from the
// single registered read port of the memory
// synchronous reset clears words_in_use, the sequencer and the result valid; map words stay unset
// ----------------------------------------------------------------------------
`default_nettype none

module extent_map_block_translator import embt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  embt_in_if.sink    req,
  embt_out_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  // sequencer
  embt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign req.ready = in_ready;

  // storage and arithmetic
  embt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .kind          (req.kind),
    .word_index    (req.word_index),
    .map_word      (req.map_word),
    .virtual_block (req.virtual_block),
    .cmd           (cmd),
    .stat          (stat),
    .rsp           (rsp)
  );

endmodule

`default_nettype wire

// ===== rtl/embt_datapath.sv =====
// ----------------------------------------------------------------------------
// embt_datapath
// extent map memory, pointer decode, running block count and result register
// ----------------------------------------------------------------------------
`default_nettype none

module embt_datapath import embt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        kind,
  input  logic [7:0]  word_index,
  input  logic [15:0] map_word,
  input  logic [30:0] virtual_block,
  input  cmd_t        cmd,
  output stat_t       stat,
  embt_out_if.source  rsp
);

  logic [7:0]       words_in_use;
  logic [15:0]      mem [MAP_WORDS];
  logic [15:0]      rd_data;
  logic             rd_zero;
  logic [30:0]      vbn;
  logic [POS_W-1:0] pos;
  logic [31:0]      block;
  logic [1:0]       k;
  logic [15:0]      w0, w1, w2, w3;
  logic [31:0]      size, base, offset;
  logic [2:0]       step;
  logic [31:0]      res_lbn;
  resp_code_t       res_code;
  logic             out_valid;
  logic [31:0]      out_lbn;
  logic [1:0]       out_code;

  logic [15:0]      word;
  logic [POS_W-1:0] limit;
  logic [POS_W-1:0] rd_addr;
  logic             wr_in_range;
  ptr_type_t        cur_type;
  ptr_type_t        ptr_type;
  logic [31:0]      end_blk;
  logic [31:0]      lbn_sum;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= 8'd0;
    end else if (cfg_we) begin
      words_in_use <= cfg_data;
    end
  end

  // words in use, saturated to the map size
  always_comb begin
    if (32'(words_in_use) > MAP_WORDS) begin
      limit = POS_W'(MAP_WORDS);
    end else begin
      limit = POS_W'(words_in_use);
    end
  end

  // read address: first word of a pointer, else the word after the one arriving
  assign rd_addr     = cmd.fetch ? (pos + POS_W'(k) + POS_W'(1)) : pos;
  assign wr_in_range = 32'(word_index) < MAP_WORDS;

  // map memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_in_range) begin
      mem[word_index[ADDR_W-1:0]] <= map_word;
    end
    if (cmd.rd_first || cmd.fetch) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
      rd_zero <= !(rd_addr < POS_W'(MAP_WORDS));
    end
  end

  // words past the end of the map read as zero
  assign word = rd_zero ? 16'd0 : rd_data;

  // pointer type of the word being fetched
  assign cur_type = (k == 2'd0) ? ptr_type_t'(word[15:14]) : ptr_type_t'(w0[15:14]);
  assign ptr_type = ptr_type_t'(w0[15:14]);

  assign end_blk = block + size;
  assign lbn_sum = base + offset;

  // walk position, running block count and fetched pointer words
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      vbn   <= virtual_block;
      pos   <= '0;
      block <= 32'd1;
    end
    if (cmd.rd_first) begin
      k <= 2'd0;
    end
    if (cmd.fetch) begin
      case (k)
        2'd0:    w0 <= word;
        2'd1:    w1 <= word;
        2'd2:    w2 <= word;
        default: w3 <= word;
      endcase
      k <= k + 2'd1;
    end
    if (cmd.advance) begin
      pos   <= pos + POS_W'(step);
      block <= end_blk;
    end
  end

  // pointer decode: count, base and length in words
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      offset <= {1'b0, vbn} - block;
      case (ptr_type)
        PTR_NONE: begin
          size <= 32'd0;
          base <= 32'd0;
          step <= 3'd1;
        end
        PTR_SHORT: begin
          size <= {24'd0, w0[7:0]} + 32'd1;
          base <= {10'd0, w0[13:8], w1};
          step <= 3'd2;
        end
        PTR_MID: begin
          size <= {18'd0, w0[13:0]} + 32'd1;
          base <= {w2, w1};
          step <= 3'd3;
        end
        default: begin
          size <= {2'd0, w0[13:0], w1} + 32'd1;
          base <= {w3, w2};
          step <= 3'd4;
        end
      endcase
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.make_ack) begin
      res_lbn  <= 32'd0;
      res_code <= RESP_ACK;
    end else if (cmd.make_eof) begin
      res_lbn  <= 32'd0;
      res_code <= RESP_EOF;
    end else if (cmd.make_lbn) begin
      if (lbn_sum == 32'd0) begin
        res_lbn  <= 32'd0;
        res_code <= RESP_BAD;
      end else begin
        res_lbn  <= lbn_sum;
        res_code <= RESP_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_lbn  <= res_lbn;
      out_code <= 2'(res_code);
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.logical_block = out_lbn;
  assign rsp.status        = out_code;

  // status back to the controller
  assign stat.kind       = kind;
  assign stat.more       = pos < limit;
  assign stat.fetch_last = (k == 2'(cur_type));
  assign stat.hit        = {1'b0, vbn} < end_blk;
  assign stat.out_free   = !out_valid || rsp.ready;

endmodule

`default_nettype wire

// ===== rtl/embt_ctrl.sv =====
// ----------------------------------------------------------------------------
// embt_ctrl
// sequencer for map writes and the pointer-by-pointer translation walk
// ----------------------------------------------------------------------------
`default_nettype none

module embt_ctrl import embt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  `include "extent_map_block_translator_assert.svh"

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (stat.kind == KIND_WRITE) ? ST_EMIT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = stat.more ? ST_FETCH : ST_EMIT;
      end
      ST_FETCH: begin
        if (stat.fetch_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = stat.hit ? ST_LBN : ST_CHECK;
      end
      ST_LBN: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd           = '0;
    cmd.wr        = accept && (stat.kind == KIND_WRITE);
    cmd.make_ack  = accept && (stat.kind == KIND_WRITE);
    cmd.walk_init = accept && (stat.kind == KIND_XLATE);
    case (state)
      ST_CHECK: begin
        cmd.rd_first = stat.more;
        cmd.make_eof = !stat.more;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
      end
      ST_CMP: begin
        cmd.advance = !stat.hit;
      end
      ST_LBN: begin
        cmd.make_lbn = 1'b1;
      end
      ST_EMIT: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
      end
    endcase
  end

  // checks
  `EMBT_ASSERT(a_load_only_when_free, cmd.out_load |-> stat.out_free, "result loaded over a waiting beat")
  `EMBT_ASSERT_NEXT(a_walk_starts_check, cmd.walk_init, state == ST_CHECK, "walk did not start with a bound check")
  `EMBT_ASSERT(a_one_result_source, $onehot0({cmd.make_lbn, cmd.make_eof, cmd.make_ack}), "two result sources in one cycle")
  `EMBT_ASSERT_NEXT(a_write_then_emit, cmd.wr, state == ST_EMIT, "map write not acknowledged next")

endmodule

`default_nettype wire
